// ----- src/memory_candidate_filter_core_assert.svh -----
// Assertion macros for the memory candidate filter checker.
// Depends on a clock named i_clk and a reset named i_rst_n in the using scope.
`ifndef MEMORY_CANDIDATE_FILTER_CORE_ASSERT_SVH
`define MEMORY_CANDIDATE_FILTER_CORE_ASSERT_SVH

// Checked while out of reset.
`define MCF_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("mcf assertion failed");

// Checked at every edge, reset included.
`define MCF_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("mcf assertion failed");

`endif

// ----- src/mcf_pkg.sv -----
// Types, constants and helpers for the memory candidate filter.
// No dependencies; used by every module of the block.
package mcf_pkg;

    localparam int MEMORY_BYTES = 2097152;
    localparam int CNT_W        = $clog2(MEMORY_BYTES);
    localparam int OUT_ADDR_W   = 21;
    localparam logic [CNT_W-1:0] LAST_ADDR = CNT_W'(MEMORY_BYTES - 1);

    typedef enum logic [2:0] {
        CFG_SEARCH_MODE = 3'd0,
        CFG_COMPARE_OP  = 3'd1,
        CFG_DATA_SIZE   = 3'd2,
        CFG_SIGNED      = 3'd3,
        CFG_UPDATE_SNAP = 3'd4,
        CFG_SEARCH_VAL  = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_SNAP  = 2'd0,
        MODE_VALUE = 2'd1,
        MODE_ADDR  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        OP_LT = 3'd0,
        OP_GT = 3'd1,
        OP_LE = 3'd2,
        OP_GE = 3'd3,
        OP_EQ = 3'd4,
        OP_NE = 3'd5
    } t_op;

    typedef struct packed {
        logic [1:0]  search_mode;
        logic [2:0]  compare_op;
        logic [1:0]  data_size;
        logic        signed_compare;
        logic        update_snapshot;
        logic [31:0] search_value;
    } t_mcf_cfg;

    typedef struct packed {
        logic [7:0] cur_byte;
        logic [7:0] snap_byte;
        logic       cand_in;
        logic       last_byte;
    } t_mcf_in;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] out_addr;
        logic                  cand_out;
        logic                  snap_write;
        logic [7:0]            snap_data;
        logic                  last_result;
    } t_mcf_out;

    typedef logic [2:0][7:0] t_byte3;

    typedef struct packed {
        logic       hold;
        logic [7:0] first_cur;
    } t_mcf_eval;

    // Extend a value of sz+1 bytes to 33 bits, sign-extending when sgn.
    function automatic logic signed [32:0] ext_val(input logic [31:0] v,
                                                   input logic [1:0]  sz,
                                                   input logic        sgn);
        logic signed [32:0] r;
        case (sz)
            2'd0:    r = {{25{sgn & v[7]}},  v[7:0]};
            2'd1:    r = {{17{sgn & v[15]}}, v[15:0]};
            2'd2:    r = {{9{sgn & v[23]}},  v[23:0]};
            default: r = {sgn & v[31],       v[31:0]};
        endcase
        return r;
    endfunction

endpackage

// ----- src/memory_candidate_filter_core.sv -----
// Top level of the memory candidate filter: input register, byte windows, result sequencer.
// Depends on mcf_pkg and mcf_eval.
//
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------
//  in      | i_in_valid / o_in_ready   | i_in_data  (t_mcf_in)
//  out     | o_out_valid / i_out_ready | o_out_data (t_mcf_out)
//  cfg     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One byte per cycle sustained while the output is ready; a byte enters the input
// register, is evaluated and moves into the result register. A final byte yields
// data_size+1 results (fewer on a short image), sent one per cycle from the result
// register while the output is ready. The input register keeps taking one transaction
// while a result waits. Synchronous active-low reset clears the windows, the address
// counter, the configuration and both valid stages.
module memory_candidate_filter_core import mcf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_mcf_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_mcf_out    o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_mcf_cfg         r_cfg;
    logic             r_a_valid;
    t_mcf_in          r_a_data;
    t_byte3           r_cur_win;
    t_byte3           r_snap_win;
    logic [2:0]       r_cand_win;
    logic [CNT_W-1:0] r_cnt;

    logic [2:0]       r_b_cnt;
    logic [CNT_W-1:0] r_b_addr;
    logic             r_b_main;
    logic             r_b_cand;
    logic             r_b_wr;
    logic [7:0]       r_b_data;
    logic             r_b_last;

    logic             a_move;
    logic             b_take;
    logic             b_done;
    logic             is_last;
    logic             has_main;
    logic [CNT_W-1:0] lag_ext;
    logic [CNT_W-1:0] main_addr;
    logic [2:0]       tail_cnt;
    logic [2:0]       n_b_cnt;
    t_mcf_eval        eval;

    assign lag_ext   = CNT_W'(r_cfg.data_size);
    assign has_main  = r_cnt >= lag_ext;
    assign main_addr = r_cnt - lag_ext;
    assign is_last   = r_a_data.last_byte || (r_cnt >= LAST_ADDR);

    // Before the window fills r_cnt < data_size <= 3, so two bits hold it.
    always_comb begin
        if (!is_last)
            tail_cnt = 3'd0;
        else if (has_main)
            tail_cnt = {1'b0, r_cfg.data_size};
        else
            tail_cnt = {1'b0, r_cnt[1:0]} + 3'd1;
        n_b_cnt = tail_cnt + {2'b00, has_main};
    end

    mcf_eval u_eval (
        .i_cfg      (r_cfg),
        .i_cur      (r_a_data.cur_byte),
        .i_snap     (r_a_data.snap_byte),
        .i_cand     (r_a_data.cand_in),
        .i_cur_win  (r_cur_win),
        .i_snap_win (r_snap_win),
        .i_cand_win (r_cand_win),
        .i_addr     (main_addr),
        .o_eval     (eval)
    );

    assign o_out_valid = r_b_cnt != 3'd0;
    assign b_take      = o_out_valid && i_out_ready;
    assign b_done      = b_take && (r_b_cnt == 3'd1);
    assign a_move      = r_a_valid && (!o_out_valid || b_done);
    assign o_in_ready  = !r_a_valid || a_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEARCH_MODE: r_cfg.search_mode     <= i_cfg_data[1:0];
                CFG_COMPARE_OP:  r_cfg.compare_op      <= i_cfg_data[2:0];
                CFG_DATA_SIZE:   r_cfg.data_size       <= i_cfg_data[1:0];
                CFG_SIGNED:      r_cfg.signed_compare  <= i_cfg_data[0];
                CFG_UPDATE_SNAP: r_cfg.update_snapshot <= i_cfg_data[0];
                CFG_SEARCH_VAL:  r_cfg.search_value    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_a_data <= i_in_data;
        end
    end

    // Windows and address counter advance as a byte moves to the result stage; the last byte clears them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_win  <= '0;
            r_snap_win <= '0;
            r_cand_win <= '0;
            r_cnt      <= '0;
        end else if (a_move) begin
            if (is_last) begin
                r_cur_win  <= '0;
                r_snap_win <= '0;
                r_cand_win <= '0;
                r_cnt      <= '0;
            end else begin
                r_cur_win  <= {r_cur_win[1:0], r_a_data.cur_byte};
                r_snap_win <= {r_snap_win[1:0], r_a_data.snap_byte};
                r_cand_win <= {r_cand_win[1:0], r_a_data.cand_in};
                r_cnt      <= r_cnt + 1'b1;
            end
        end
    end

    // Result register: a run of consecutive addresses, the first one possibly live.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_cnt <= 3'd0;
        end else if (a_move) begin
            r_b_cnt <= n_b_cnt;
        end else if (b_take) begin
            r_b_cnt <= r_b_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_addr <= has_main ? main_addr : '0;
            r_b_main <= has_main;
            r_b_cand <= eval.hold;
            r_b_wr   <= eval.hold && r_cfg.update_snapshot;
            r_b_data <= (eval.hold && r_cfg.update_snapshot) ? eval.first_cur : 8'd0;
            r_b_last <= is_last;
        end else if (b_take) begin
            r_b_addr <= r_b_addr + 1'b1;
            r_b_main <= 1'b0;
        end
    end

    assign o_out_data.out_addr    = OUT_ADDR_W'(r_b_addr);
    assign o_out_data.cand_out    = r_b_main && r_b_cand;
    assign o_out_data.snap_write  = r_b_main && r_b_wr;
    assign o_out_data.snap_data   = r_b_main ? r_b_data : 8'd0;
    assign o_out_data.last_result = r_b_last && (r_b_cnt == 3'd1);

endmodule

// ----- src/mcf_eval.sv -----
// Value assembly and relation test for one address of the memory candidate filter.
// Depends on mcf_pkg.
module mcf_eval import mcf_pkg::*; (
    input  t_mcf_cfg         i_cfg,
    input  logic [7:0]       i_cur,
    input  logic [7:0]       i_snap,
    input  logic             i_cand,
    input  t_byte3           i_cur_win,
    input  t_byte3           i_snap_win,
    input  logic [2:0]       i_cand_win,
    input  logic [CNT_W-1:0] i_addr,
    output t_mcf_eval        o_eval
);

    logic [31:0]        cu;
    logic [31:0]        su;
    logic [7:0]         first_cur;
    logic               first_cand;
    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic               mode_ok;
    logic               lt;
    logic               eq;
    logic               rel;

    // Oldest byte is the low byte of the value.
    always_comb begin
        case (i_cfg.data_size)
            2'd0: begin
                cu         = {24'd0, i_cur};
                su         = {24'd0, i_snap};
                first_cur  = i_cur;
                first_cand = i_cand;
            end
            2'd1: begin
                cu         = {16'd0, i_cur, i_cur_win[0]};
                su         = {16'd0, i_snap, i_snap_win[0]};
                first_cur  = i_cur_win[0];
                first_cand = i_cand_win[0];
            end
            2'd2: begin
                cu         = {8'd0, i_cur, i_cur_win[0], i_cur_win[1]};
                su         = {8'd0, i_snap, i_snap_win[0], i_snap_win[1]};
                first_cur  = i_cur_win[1];
                first_cand = i_cand_win[1];
            end
            default: begin
                cu         = {i_cur, i_cur_win[0], i_cur_win[1], i_cur_win[2]};
                su         = {i_snap, i_snap_win[0], i_snap_win[1], i_snap_win[2]};
                first_cur  = i_cur_win[2];
                first_cand = i_cand_win[2];
            end
        endcase
    end

    always_comb begin
        mode_ok = 1'b1;
        op_a    = ext_val(cu, i_cfg.data_size, i_cfg.signed_compare);
        case (i_cfg.search_mode)
            MODE_SNAP:  op_b = ext_val(su, i_cfg.data_size, i_cfg.signed_compare);
            MODE_VALUE: op_b = ext_val(i_cfg.search_value, 2'd3, i_cfg.signed_compare);
            MODE_ADDR: begin
                op_a = signed'({{(33-CNT_W){1'b0}}, i_addr});
                op_b = ext_val(i_cfg.search_value, 2'd3, 1'b1);
            end
            default: begin
                op_b    = '0;
                mode_ok = 1'b0;
            end
        endcase
    end

    assign lt = op_a < op_b;
    assign eq = op_a == op_b;

    always_comb begin
        case (i_cfg.compare_op)
            OP_LT:   rel = lt;
            OP_GT:   rel = !lt && !eq;
            OP_LE:   rel = lt || eq;
            OP_GE:   rel = !lt;
            OP_EQ:   rel = eq;
            default: rel = !eq;
        endcase
    end

    assign o_eval.hold      = rel && mode_ok && first_cand;
    assign o_eval.first_cur = first_cur;

endmodule

// ----- src/mcf_checker.sv -----
// Port-level assertions for memory_candidate_filter_core, bound to the top level.
// Depends on mcf_pkg and memory_candidate_filter_core_assert.svh.
`include "memory_candidate_filter_core_assert.svh"

module mcf_checker import mcf_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_mcf_out o_out_data
);

    // A stalled result transaction keeps its payload.
    `MCF_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))

    // Only a surviving candidate rewrites its snapshot byte.
    `MCF_ASSERT(a_wr_needs_cand, o_out_valid && o_out_data.snap_write |-> o_out_data.cand_out)

    // Snapshot data is zero unless written.
    `MCF_ASSERT(a_data_zero, o_out_valid && !o_out_data.snap_write |-> o_out_data.snap_data == 8'd0)

    // Nothing is offered in the cycle after reset.
    `MCF_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid)

endmodule

bind memory_candidate_filter_core mcf_checker u_mcf_checker (.*);
